// ===== rtl/fdd_pkg.sv =====
package fdd_pkg;

  localparam int NAME_BUFFER_BYTES_DEF     = 256;
  localparam int MAX_LONG_NAME_ENTRIES_DEF = 20;
  localparam int CHARS_PER_LFN             = 13;
  localparam int MAX_NAME_CHARS            = 256;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_DELETED = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;
  localparam logic [7:0] ATTR_DIR     = 8'h10;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [15:0] UCS_FILL    = 16'hFFFF;
  localparam logic [15:0] UCS_NUL     = 16'h0000;

  // Entry classes reported by the datapath.
  localparam logic [2:0] CLS_ENDED    = 3'd0;
  localparam logic [2:0] CLS_END_MARK = 3'd1;
  localparam logic [2:0] CLS_SKIP     = 3'd2;
  localparam logic [2:0] CLS_LFN      = 3'd3;
  localparam logic [2:0] CLS_SHORT    = 3'd4;

  typedef struct packed {
    logic load;
    logic emit_end;
    logic skip;
    logic lfn_start;
    logic lfn_wr;
    logic name_start;
    logic rd_issue;
    logic push;
    logic finish;
  } fdd_cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       lfn_full;
    logic       lfn_last;
    logic       is_long;
    logic       more;
    logic       term;
    logic       push_blocked;
    logic       fin_blocked;
    logic       out_full;
  } fdd_status_t;

  // Byte offset of each UTF-16 character inside a long-name entry.
  function automatic logic [4:0] lfn_offset(input logic [3:0] k);
    logic [4:0] o;
    case (k)
      4'd0:    o = 5'd1;
      4'd1:    o = 5'd3;
      4'd2:    o = 5'd5;
      4'd3:    o = 5'd7;
      4'd4:    o = 5'd9;
      4'd5:    o = 5'd14;
      4'd6:    o = 5'd16;
      4'd7:    o = 5'd18;
      4'd8:    o = 5'd20;
      4'd9:    o = 5'd22;
      4'd10:   o = 5'd24;
      4'd11:   o = 5'd28;
      4'd12:   o = 5'd30;
      default: o = 5'd1;
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/fdd_ram.sv =====
module fdd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 260
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fdd_ctrl.sv =====
module fdd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdd_pkg::fdd_status_t st,
  output fdd_pkg::fdd_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLASS  = 3'd1;
  localparam logic [2:0] S_LFN_WR = 3'd2;
  localparam logic [2:0] S_NAME   = 3'd3;
  localparam logic [2:0] S_NAME_D = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        case (st.cls)
          fdd_pkg::CLS_END_MARK: begin
            if (!st.out_full) begin
              cmd.emit_end = 1'b1;
              state_next   = S_IDLE;
            end
          end
          fdd_pkg::CLS_SKIP: begin
            cmd.skip   = 1'b1;
            state_next = S_IDLE;
          end
          fdd_pkg::CLS_LFN: begin
            if (st.lfn_full) begin
              state_next = S_IDLE;
            end else begin
              cmd.lfn_start = 1'b1;
              state_next    = S_LFN_WR;
            end
          end
          fdd_pkg::CLS_SHORT: begin
            cmd.name_start = 1'b1;
            state_next     = S_NAME;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LFN_WR: begin
        cmd.lfn_wr = 1'b1;
        if (st.lfn_last) begin
          state_next = S_IDLE;
        end
      end
      S_NAME: begin
        if (!st.more) begin
          state_next = S_FIN;
        end else if (st.is_long) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_NAME_D;
        end else if (!st.push_blocked) begin
          cmd.push = 1'b1;
        end
      end
      S_NAME_D: begin
        if (st.term) begin
          state_next = S_FIN;
        end else if (!st.push_blocked) begin
          cmd.push   = 1'b1;
          state_next = S_NAME;
        end
      end
      S_FIN: begin
        if (!st.fin_blocked) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/fdd_datapath.sv =====
module fdd_datapath #(
  parameter int NAME_BUFFER_BYTES     = fdd_pkg::NAME_BUFFER_BYTES_DEF,
  parameter int MAX_LONG_NAME_ENTRIES = fdd_pkg::MAX_LONG_NAME_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fdd_pkg::fdd_cmd_t     cmd,
  output fdd_pkg::fdd_status_t  st,
  input  logic [255:0]         in_entry,
  input  logic                 in_restart,
  input  logic                 cfg_wen,
  input  logic [15:0]          cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [63:0]          out_chars,
  output logic [3:0]           out_count,
  output logic                 out_last,
  output logic [31:0]          out_cluster,
  output logic                 out_dir,
  output logic [15:0]          out_pos
);

  localparam int DEPTH = MAX_LONG_NAME_ENTRIES * fdd_pkg::CHARS_PER_LFN;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_LONG_NAME_ENTRIES + 1);
  localparam int LIM   = (NAME_BUFFER_BYTES - 1 < fdd_pkg::MAX_NAME_CHARS) ?
                         NAME_BUFFER_BYTES - 1 : fdd_pkg::MAX_NAME_CHARS;

  logic [255:0]  entry;
  logic [7:0]    eb [32];
  logic [16:0]   pos;
  logic [CW-1:0] lfn_cnt;
  logic [CW-1:0] walk_cnt;
  logic          ended;
  logic [15:0]   start_pos;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [3:0]    k;
  logic [3:0]    j;
  logic [8:0]    len;
  logic [63:0]   chunk;
  logic [3:0]    ccount;
  logic          is_long;
  logic          silent;
  logic [8:0]    rdata;

  always_comb begin
    for (int b = 0; b < 32; b++) begin
      eb[b] = entry[b*8 +: 8];
    end
  end

  logic [7:0] attr;
  logic       is_dir;
  assign attr   = eb[11];
  assign is_dir = (attr & fdd_pkg::ATTR_DIR) != 8'h00;

  // 8.3 name: base up to the first space, then, for a file with a non-blank extension, a dot and the trimmed extension.
  logic [3:0] n8;
  logic [3:0] ext_len;
  logic [3:0] slen;
  logic       seen_space;
  always_comb begin
    n8         = 4'd8;
    seen_space = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!seen_space && eb[i] == fdd_pkg::CHAR_SPACE) begin
        n8         = 4'(i);
        seen_space = 1'b1;
      end
    end
    ext_len = 4'd0;
    for (int i = 0; i < 3; i++) begin
      if (eb[8+i] != fdd_pkg::CHAR_SPACE) begin
        ext_len = 4'(i + 1);
      end
    end
    slen = (is_dir || ext_len == 4'd0) ? n8 : n8 + 4'd1 + ext_len;
  end

  logic [7:0] short_char;
  logic [3:0] ext_idx;
  always_comb begin
    ext_idx = 4'd8 + j - n8 - 4'd1;
    if (j < n8) begin
      short_char = eb[{2'b00, j[2:0]}];
    end else if (j == n8) begin
      short_char = fdd_pkg::CHAR_DOT;
    end else begin
      short_char = eb[{1'b0, ext_idx}];
    end
  end

  // Long-name character being written.
  logic [4:0]  off;
  logic [15:0] ucs;
  logic [8:0]  wdata;
  assign off   = fdd_pkg::lfn_offset(k);
  assign ucs   = {eb[5'(off + 5'd1)], eb[off]};
  assign wdata = {(ucs == fdd_pkg::UCS_NUL) || (ucs == fdd_pkg::UCS_FILL), ucs[7:0]};

  fdd_ram #(.WIDTH(9), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.lfn_wr),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (cmd.rd_issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  logic [7:0]  push_char;
  logic        dot;
  logic [15:0] pos_sat;
  logic [31:0] cluster;
  assign push_char = is_long ? rdata[7:0] : short_char;
  assign dot = (len == 9'd1 && chunk[7:0] == fdd_pkg::CHAR_DOT) ||
               (len == 9'd2 && chunk[7:0] == fdd_pkg::CHAR_DOT &&
                chunk[15:8] == fdd_pkg::CHAR_DOT);
  assign pos_sat = pos[16] ? 16'hFFFF : pos[15:0];
  assign cluster = {eb[21], eb[20], eb[27], eb[26]};

  always_comb begin
    if (ended) begin
      st.cls = fdd_pkg::CLS_ENDED;
    end else if (eb[0] == fdd_pkg::BYTE_END) begin
      st.cls = fdd_pkg::CLS_END_MARK;
    end else if (eb[0] == fdd_pkg::BYTE_DELETED || attr == fdd_pkg::ATTR_VOLUME) begin
      st.cls = fdd_pkg::CLS_SKIP;
    end else if ((attr & fdd_pkg::ATTR_LFN) == fdd_pkg::ATTR_LFN) begin
      st.cls = fdd_pkg::CLS_LFN;
    end else begin
      st.cls = fdd_pkg::CLS_SHORT;
    end
    st.lfn_full     = 32'(lfn_cnt) >= MAX_LONG_NAME_ENTRIES;
    st.lfn_last     = (k == 4'd12);
    st.is_long      = is_long;
    st.more         = (32'(len) < LIM) && (is_long ? (walk_cnt != '0) : (j < slen));
    st.term         = rdata[8];
    st.push_blocked = (ccount == 4'd8) && out_valid && !silent;
    st.fin_blocked  = out_valid && !dot && !silent;
    st.out_full     = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      lfn_cnt   <= '0;
      ended     <= 1'b0;
      start_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        start_pos <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load && in_restart) begin
        pos     <= '0;
        lfn_cnt <= '0;
        ended   <= 1'b0;
      end
      if (cmd.emit_end) begin
        ended     <= 1'b1;
        lfn_cnt   <= '0;
        out_valid <= 1'b1;
      end
      if (cmd.skip || cmd.finish) begin
        if (pos != 17'h1FFFF) begin
          pos <= pos + 17'd1;
        end
      end
      if (cmd.skip || cmd.name_start) begin
        lfn_cnt <= '0;
      end
      if (cmd.lfn_wr && k == 4'd12) begin
        lfn_cnt <= lfn_cnt + CW'(1);
      end
      if (cmd.push && ccount == 4'd8 && !silent) begin
        out_valid <= 1'b1;
      end
      if (cmd.finish && !dot && !silent) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry <= in_entry;
    end
    if (cmd.lfn_start) begin
      wr_addr <= AW'(32'(lfn_cnt) * fdd_pkg::CHARS_PER_LFN);
      k       <= 4'd0;
    end
    if (cmd.lfn_wr) begin
      wr_addr <= wr_addr + AW'(1);
      k       <= k + 4'd1;
    end
    if (cmd.name_start) begin
      rd_addr  <= AW'((32'(lfn_cnt) - 32'd1) * fdd_pkg::CHARS_PER_LFN);
      walk_cnt <= lfn_cnt;
      is_long  <= (lfn_cnt != '0);
      silent   <= 32'(pos) < 32'(start_pos);
      k        <= 4'd0;
      j        <= 4'd0;
      len      <= '0;
      chunk    <= '0;
      ccount   <= '0;
    end
    if (cmd.push) begin
      len <= len + 9'd1;
      if (ccount == 4'd8) begin
        chunk  <= {56'd0, push_char};
        ccount <= 4'd1;
      end else begin
        chunk[ccount[2:0]*8 +: 8] <= push_char;
        ccount                    <= ccount + 4'd1;
      end
      if (is_long) begin
        if (k == 4'd12) begin
          k        <= 4'd0;
          walk_cnt <= walk_cnt - CW'(1);
          rd_addr  <= rd_addr - AW'(25);
        end else begin
          k       <= k + 4'd1;
          rd_addr <= rd_addr + AW'(1);
        end
      end else begin
        j <= j + 4'd1;
      end
    end
    if (cmd.emit_end) begin
      out_kind    <= 1'b1;
      out_chars   <= '0;
      out_count   <= '0;
      out_last    <= 1'b1;
      out_cluster <= '0;
      out_dir     <= 1'b0;
      out_pos     <= pos_sat;
    end
    if (cmd.push && ccount == 4'd8 && !silent) begin
      out_kind    <= 1'b0;
      out_chars   <= chunk;
      out_count   <= 4'd8;
      out_last    <= 1'b0;
      out_cluster <= cluster;
      out_dir     <= is_dir;
      out_pos     <= pos_sat;
    end
    if (cmd.finish && !dot && !silent) begin
      out_kind    <= 1'b0;
      out_chars   <= chunk;
      out_count   <= ccount;
      out_last    <= 1'b1;
      out_cluster <= cluster;
      out_dir     <= is_dir;
      out_pos     <= pos_sat;
    end
  end

endmodule

// ===== rtl/fat_directory_entry_decoder_core.sv =====
// FAT32 directory entry decoder.
// The slave stream carries one 32-byte on-disk directory entry per transaction
// in tdata, byte 0 in the lowest bits; tuser is the restart flag, which clears
// the position counter, the long-name buffer and the end mark first.
// The master stream carries result transactions: tuser is the kind (0 for a
// name chunk, 1 for end of directory), tlast marks the final result of an
// entry, and tdata packs up to eight name characters with the entry details.
// Entries are handled one at a time. Deleted entries and volume labels are
// skipped, a long-name entry writes its 13 characters into the name RAM,
// and an 8.3 name is pushed out character by character.
// A long name is read back from the name RAM one character at a time, as
// the RAM has a single read port: each character is read, then pushed, and
// a terminator ends the name.
// Results leave through an output register; when the receiver stalls, the
// block waits with the next chunk until the register is free, and a new
// entry is only taken once the current one has been fully processed.
// Reset (rst, synchronous) clears the position, the end mark, the long-name
// count and start_position; the name RAM needs no clearing.
module fat_directory_entry_decoder_core #(
  parameter int NAME_BUFFER_BYTES     = fdd_pkg::NAME_BUFFER_BYTES_DEF,
  parameter int MAX_LONG_NAME_ENTRIES = fdd_pkg::MAX_LONG_NAME_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_bytes_lo [63:0], entry_bytes_midlo [127:64],
  // entry_bytes_midhi [191:128], entry_bytes_hi [255:192]
  input  logic [255:0] s_axis_tdata,
  // restart [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // name_chars [63:0], char_count [67:64], start_cluster [99:68],
  // is_directory [100], entry_position [116:101], zero padding [119:117]
  output logic [119:0] m_axis_tdata,
  // kind [0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata
);

  fdd_pkg::fdd_cmd_t    cmd;
  fdd_pkg::fdd_status_t st;

  logic [63:0] out_chars;
  logic [3:0]  out_count;
  logic [31:0] out_cluster;
  logic        out_dir;
  logic [15:0] out_pos;

  // The controller sequences each entry; the datapath holds the entry, the counters and the name RAM.
  fdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  fdd_datapath #(
    .NAME_BUFFER_BYTES     (NAME_BUFFER_BYTES),
    .MAX_LONG_NAME_ENTRIES (MAX_LONG_NAME_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_entry    (s_axis_tdata),
    .in_restart  (s_axis_tuser),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_chars   (out_chars),
    .out_count   (out_count),
    .out_last    (m_axis_tlast),
    .out_cluster (out_cluster),
    .out_dir     (out_dir),
    .out_pos     (out_pos)
  );

  assign m_axis_tdata = {3'b000, out_pos, out_dir, out_cluster, out_count, out_chars};

endmodule

// ===== test/fdd_scoreboard.sv =====
module fdd_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           pending_chunks
);

  typedef struct packed {
    logic         kind;
    logic         last;
    logic [119:0] data;
  } chunk_t;

  chunk_t      chunk_q[$];
  logic [15:0] lfn_ram [0:fdd_pkg::MAX_LONG_NAME_ENTRIES_DEF*fdd_pkg::CHARS_PER_LFN-1];
  int          lfn_held;
  int          position;
  logic        ended;
  logic [15:0] first_pos;

  assign pending_chunks = chunk_q.size();

  // Work out every result one entry causes and append them to the queue.
  task automatic decode_entry(input logic [255:0] d, input logic restart);
    logic [7:0]  eb [0:31];
    logic [7:0]  nm [0:263];
    logic [7:0]  attr;
    logic        is_dir;
    logic [31:0] clus;
    logic [15:0] c;
    logic [15:0] opos;
    logic [63:0] w;
    chunk_t      r;
    int len, lim, ext, nch, cnt, base;
    bit stop;
    len = 0; lim = fdd_pkg::NAME_BUFFER_BYTES_DEF - 1; ext = 0; stop = 0;
    if (lim > 256) lim = 256;
    if (restart) begin
      position = 0;
      lfn_held = 0;
      ended = 1'b0;
    end
    if (ended) return;
    for (int b = 0; b < 32; b++) eb[b] = d[b*8 +: 8];
    attr = eb[11];
    opos = (position > 65535) ? 16'hFFFF : position[15:0];
    if (eb[0] == fdd_pkg::BYTE_END) begin
      ended = 1'b1;
      lfn_held = 0;
      r.kind = 1'b1;
      r.last = 1'b1;
      r.data = '0;
      r.data[116:101] = opos;
      chunk_q.push_back(r);
      return;
    end
    if (eb[0] == fdd_pkg::BYTE_DELETED || attr == fdd_pkg::ATTR_VOLUME) begin
      lfn_held = 0;
      if (position < 131071) position++;
      return;
    end
    if ((attr & fdd_pkg::ATTR_LFN) == fdd_pkg::ATTR_LFN) begin
      if (lfn_held < fdd_pkg::MAX_LONG_NAME_ENTRIES_DEF) begin
        base = lfn_held * fdd_pkg::CHARS_PER_LFN;
        for (int k = 0; k < fdd_pkg::CHARS_PER_LFN; k++)
          lfn_ram[base+k] = {eb[fdd_pkg::lfn_offset(4'(k))+1],
                             eb[fdd_pkg::lfn_offset(4'(k))]};
        lfn_held++;
      end
      return;
    end
    is_dir = (attr & fdd_pkg::ATTR_DIR) != 0;
    if (lfn_held > 0) begin
      // The last long-name entry to arrive holds the start of the name.
      for (int i = lfn_held; i > 0 && !stop; i--) begin
        for (int k = 0; k < fdd_pkg::CHARS_PER_LFN && !stop; k++) begin
          c = lfn_ram[(i-1)*fdd_pkg::CHARS_PER_LFN + k];
          if (c == fdd_pkg::UCS_NUL || c == fdd_pkg::UCS_FILL || len >= lim) stop = 1;
          else begin
            nm[len] = c[7:0];
            len++;
          end
        end
      end
    end else begin
      for (int i = 0; i < 8 && eb[i] != fdd_pkg::CHAR_SPACE; i++) begin
        nm[len] = eb[i];
        len++;
      end
      if (!is_dir) begin
        for (int i = 0; i < 3; i++) if (eb[8+i] != fdd_pkg::CHAR_SPACE) ext = i + 1;
        if (ext > 0) begin
          nm[len] = fdd_pkg::CHAR_DOT;
          len++;
          for (int i = 0; i < ext; i++) begin
            nm[len] = eb[8+i];
            len++;
          end
        end
      end
    end
    lfn_held = 0;
    if (len >= 1 && nm[0] == fdd_pkg::CHAR_DOT &&
        (len == 1 || (len == 2 && nm[1] == fdd_pkg::CHAR_DOT))) begin
      if (position < 131071) position++;
      return;
    end
    if (position < first_pos) begin
      position++;
      return;
    end
    clus = {eb[21], eb[20], eb[27], eb[26]};
    nch = (len == 0) ? 1 : (len + 7) / 8;
    for (int ci = 0; ci < nch; ci++) begin
      cnt = len - ci*8;
      if (cnt > 8) cnt = 8;
      w = '0;
      for (int i = 0; i < cnt; i++) w[i*8 +: 8] = nm[ci*8 + i];
      r.kind = 1'b0;
      r.last = (ci + 1 == nch);
      r.data = {3'b000, opos, is_dir, clus, cnt[3:0], w};
      chunk_q.push_back(r);
    end
    if (position < 131071) position++;
  endtask

  always @(posedge clk) begin
    chunk_t e;
    if (rst) begin
      lfn_held = 0;
      position = 0;
      ended = 1'b0;
      first_pos = '0;
      fail_count <= 0;
    end else begin
      if (cfg_wen) first_pos = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) decode_entry(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (chunk_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = chunk_q.pop_front();
          if (e.kind !== m_axis_tuser || e.last !== m_axis_tlast || e.data !== m_axis_tdata) begin
            if (fail_count < 10)
              $display("mismatch: expected kind %b last %b data %h, got kind %b last %b data %h",
                       e.kind, e.last, e.data, m_axis_tuser, m_axis_tlast, m_axis_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_fat_directory_entry_decoder_core.sv =====
module tb_fat_directory_entry_decoder_core;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_wen = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending_chunks;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           quiet_cycles = 0;

  always #5 clk = ~clk;

  fat_directory_entry_decoder_core DUT (.*);
  fdd_scoreboard checker_i (.*);

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // The watchdog counts cycles in which no transaction completes on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One entry is offered and held until the block accepts the transaction.
  // tvalid stays high afterwards until the next idle cycle or the caller drops it.
  task automatic send_entry(input logic [255:0] d, input logic restart);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tuser  <= restart;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [255:0] rand_bits();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  // A short entry whose first byte avoids the end and deleted marks, and
  // whose attribute is neither a long-name nor a volume-label code.
  function automatic logic [255:0] short_entry(input bit dir);
    logic [255:0] v;
    v = rand_bits();
    for (int i = 0; i < 11; i++)
      if ($urandom_range(3) == 0) v[i*8 +: 8] = fdd_pkg::CHAR_SPACE;
    if (v[7:0] == fdd_pkg::BYTE_END || v[7:0] == fdd_pkg::BYTE_DELETED) v[7:0] = 8'h41;
    v[95:88] = {3'($urandom_range(7)), dir, 4'($urandom_range(6))};
    if (v[91:88] == 4'h8) v[91:88] = 4'h1;
    return v;
  endfunction

  function automatic logic [255:0] lfn_entry(input bit terminate);
    logic [255:0] v;
    v = rand_bits();
    if (v[7:0] == fdd_pkg::BYTE_END || v[7:0] == fdd_pkg::BYTE_DELETED) v[7:0] = 8'h01;
    v[95:88] = {4'($urandom), fdd_pkg::ATTR_LFN[3:0]};
    if (terminate) v[fdd_pkg::lfn_offset(4'($urandom_range(12)))*8 +: 16] =
      $urandom_range(1) ? fdd_pkg::UCS_FILL : fdd_pkg::UCS_NUL;
    return v;
  endfunction

  // Writes the start register only once the block has drained.
  task automatic set_first(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_chunks != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_wdata <= v;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic random_entry();
    int sel;
    logic [255:0] v;
    sel = $urandom_range(99);
    if (sel < 35) send_entry(short_entry(1'($urandom_range(1))), 1'b0);
    else if (sel < 70) begin
      repeat ($urandom_range(1, 3)) send_entry(lfn_entry($urandom_range(3) == 0), 1'b0);
      send_entry(short_entry(1'($urandom_range(1))), 1'b0);
    end else if (sel < 80) begin
      v = rand_bits();
      v[7:0] = fdd_pkg::BYTE_DELETED;
      send_entry(v, 1'b0);
    end else if (sel < 85) begin
      v = short_entry(1'b0);
      v[95:88] = fdd_pkg::ATTR_VOLUME;
      send_entry(v, 1'b0);
    end else if (sel < 89) begin
      v = rand_bits();
      v[7:0] = fdd_pkg::BYTE_END;
      send_entry(v, 1'b0);
    end else if (sel < 95) send_entry(rand_bits(), 1'b1);
    else send_entry(rand_bits(), 1'b0);
  endtask

  initial begin
    logic [255:0] v;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed entries: plain names, dot entries, an empty name, a long name
    // with a terminator, the longest name, skips and the end mark.
    v = {256{1'b1}};
    v[95:88] = 8'h00;
    send_entry(v, 1'b1);
    v = {160'h0, 8'h00, {11{fdd_pkg::CHAR_SPACE}}};
    v[7:0] = fdd_pkg::CHAR_DOT;
    send_entry(v, 1'b0);
    v[15:8] = fdd_pkg::CHAR_DOT;
    send_entry(v, 1'b0);
    v = {160'h0, fdd_pkg::ATTR_DIR, {11{fdd_pkg::CHAR_SPACE}}};
    v[7:0] = 8'h20;
    send_entry(v, 1'b0);
    send_entry(lfn_entry(1'b1), 1'b0);
    send_entry(lfn_entry(1'b0), 1'b0);
    send_entry(short_entry(1'b1), 1'b0);
    for (int i = 0; i < 22; i++) begin
      v = {256{1'b1}};
      v[95:88] = 8'hFF;
      v[7:0] = 8'h41;
      for (int k = 0; k < 13; k++)
        v[fdd_pkg::lfn_offset(4'(k))*8 +: 16] = 16'(16'h0041 + i);
      send_entry(v, 1'b0);
    end
    send_entry(short_entry(1'b0), 1'b0);
    v = rand_bits();
    v[7:0] = fdd_pkg::BYTE_DELETED;
    send_entry(v, 1'b0);
    v = short_entry(1'b0);
    v[95:88] = fdd_pkg::ATTR_VOLUME;
    send_entry(v, 1'b0);
    send_entry({256{1'b0}}, 1'b0);
    send_entry(short_entry(1'b0), 1'b0);

    // Random phases with different idling and start positions.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      if (ph == 2) set_first(16'hFFFF);
      else if (ph == 3) set_first(16'd5);
      else if (ph == 5) set_first(16'd0);
      send_entry(short_entry(1'b0), 1'b1);
      repeat (27) random_entry();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_chunks != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/fdd_pkg.sv
rtl/fdd_ram.sv
rtl/fdd_ctrl.sv
rtl/fdd_datapath.sv
rtl/fat_directory_entry_decoder_core.sv
test/fdd_scoreboard.sv
test/tb_fat_directory_entry_decoder_core.sv
